// ===== rtl/turtle_grid_plotter_unit_macros.svh =====
// assertion macros used by the plotter checker
// no dependencies
`ifndef TURTLE_GRID_PLOTTER_UNIT_MACROS_SVH
`define TURTLE_GRID_PLOTTER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TGP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plotter check failed");

// next-cycle implication, disabled during reset
`define TGP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plotter check failed");

`endif

// ===== rtl/tgp_pkg.sv =====
// shared constants for the turtle grid plotter: grid geometry, field widths,
// command and heading codes; no dependencies
package tgp_pkg;

    localparam int GRID_SIZE = 64;
    localparam int START_POS = 32;

    localparam int ROW_BITS = 64;
    localparam int KIND_W   = 3;
    localparam int STEPS_W  = 6;
    localparam int INDEX_W  = 6;

    localparam int POS_W = $clog2(GRID_SIZE);
    localparam int CNT_W = $clog2(GRID_SIZE + 1);
    localparam int SHW   = $clog2(ROW_BITS + 1);

    localparam int START_CLAMP = (START_POS < GRID_SIZE) ? START_POS : GRID_SIZE - 1;

    localparam logic [KIND_W-1:0] KIND_PEN_UP   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PEN_DOWN = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TURN_R   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TURN_L   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MOVE     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DUMP     = 3'd5;

    // headings: west = decreasing column, south = increasing row
    localparam logic [1:0] HEAD_W = 2'd0;
    localparam logic [1:0] HEAD_S = 2'd1;
    localparam logic [1:0] HEAD_E = 2'd2;
    localparam logic [1:0] HEAD_N = 2'd3;

endpackage

// ===== rtl/turtle_grid_plotter_unit.sv =====
// turtle grid plotter top level: grid rows in a synchronous memory, read-modify-write
// sequencer; depends on tgp_pkg
// pen, turn and non-marking move results are registered, unused codes give no result; a
// marking move over r rows (1 for a horizontal move) does one read per row, then gives
// one result; a dump gives one row per cycle from the single read port; next transaction
// once busy drops; results cannot stall; async reset clears control state and row valid bits
module turtle_grid_plotter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [2:0]  kind,
    input  logic [5:0]  steps,
    output logic        busy,
    output logic        done,
    output logic [63:0] row_bits,
    output logic [5:0]  row_index,
    output logic        status,
    output logic        last
);

    localparam int G   = tgp_pkg::GRID_SIZE;
    localparam int PW  = tgp_pkg::POS_W;
    localparam int CW  = tgp_pkg::CNT_W;
    localparam int SW  = tgp_pkg::SHW;
    localparam int RB  = tgp_pkg::ROW_BITS;
    localparam int IW  = tgp_pkg::INDEX_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MARK = 3'b010,
        ST_DUMP = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic            pen_reg, pen_next;
    logic [1:0]      heading_reg, heading_next;
    logic [PW-1:0]   row_pos_reg, row_pos_next;
    logic [PW-1:0]   col_pos_reg, col_pos_next;
    logic [RB-1:0]   mask_reg, mask_next;
    logic [PW-1:0]   rd_addr_reg, rd_addr_next;
    logic [CW-1:0]   rd_left_reg, rd_left_next;
    logic            pend_reg, pend_next;
    logic [PW-1:0]   pend_addr_reg, pend_addr_next;
    logic            clamp_reg, clamp_next;
    logic [G-1:0]    row_valid_reg, row_valid_next;

    logic            done_reg, done_next;
    logic [RB-1:0]   row_bits_reg, row_bits_next;
    logic [IW-1:0]   row_index_reg, row_index_next;
    logic            status_reg, status_next;
    logic            last_reg, last_next;

    logic [RB-1:0]   mem [G];
    logic [RB-1:0]   mem_q;
    logic            q_valid_reg;

    logic            accept;
    logic            rd_en;
    logic            wr_en;
    logic [RB-1:0]   row_data;
    logic [RB-1:0]   wr_data;

    // move geometry
    logic            horiz;
    logic            inc;
    logic [PW-1:0]   cur_p;
    logic [PW-1:0]   room;
    logic [SW-1:0]   n_ext;
    logic [SW-1:0]   room_ext;
    logic            clamp;
    logic [SW-1:0]   mark_cnt;
    logic [PW-1:0]   new_p;
    logic [PW-1:0]   lo;
    logic [RB-1:0]   run_mask;
    logic [RB-1:0]   col_mask;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && (state_reg == ST_IDLE);
    assign rd_en     = (state_reg != ST_IDLE) && (rd_left_reg != '0);
    assign wr_en     = (state_reg == ST_MARK) && pend_reg;
    assign row_data  = q_valid_reg ? mem_q : '0;
    assign wr_data   = row_data | mask_reg;

    assign done      = done_reg;
    assign row_bits  = row_bits_reg;
    assign row_index = row_index_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    always_comb
    begin
        horiz    = (heading_reg == tgp_pkg::HEAD_W) || (heading_reg == tgp_pkg::HEAD_E);
        inc      = (heading_reg == tgp_pkg::HEAD_S) || (heading_reg == tgp_pkg::HEAD_E);
        cur_p    = horiz ? col_pos_reg : row_pos_reg;
        room     = inc ? (PW'(G - 1) - cur_p) : cur_p;
        n_ext    = SW'(steps);
        room_ext = SW'(room);
        clamp    = n_ext > room_ext;
        // cells inside the grid, edge cell included
        mark_cnt = clamp ? (room_ext + SW'(1)) : n_ext;
        if (clamp)
        begin
            new_p = inc ? PW'(G - 1) : '0;
        end
        else
        begin
            new_p = inc ? (cur_p + PW'(steps)) : (cur_p - PW'(steps));
        end
        lo       = inc ? cur_p : PW'(SW'(cur_p) + SW'(1) - mark_cnt);
        run_mask = (mark_cnt == '0) ? '0
                 : (({RB{1'b1}} >> (SW'(RB) - mark_cnt)) << lo);
        col_mask = RB'(1) << col_pos_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        pen_next       = pen_reg;
        heading_next   = heading_reg;
        row_pos_next   = row_pos_reg;
        col_pos_next   = col_pos_reg;
        mask_next      = mask_reg;
        rd_addr_next   = rd_addr_reg;
        rd_left_next   = rd_left_reg;
        pend_next      = rd_en;
        pend_addr_next = rd_addr_reg;
        clamp_next     = clamp_reg;
        row_valid_next = row_valid_reg;
        done_next      = 1'b0;
        row_bits_next  = '0;
        row_index_next = '0;
        status_next    = 1'b0;
        last_next      = 1'b0;

        if (rd_en)
        begin
            rd_addr_next = rd_addr_reg + PW'(1);
            rd_left_next = rd_left_reg - CW'(1);
        end

        if (wr_en)
        begin
            row_valid_next[pend_addr_reg] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind)
                        tgp_pkg::KIND_PEN_UP:
                        begin
                            pen_next  = 1'b0;
                            done_next = 1'b1;
                            last_next = 1'b1;
                        end
                        tgp_pkg::KIND_PEN_DOWN:
                        begin
                            pen_next  = 1'b1;
                            done_next = 1'b1;
                            last_next = 1'b1;
                        end
                        tgp_pkg::KIND_TURN_R:
                        begin
                            heading_next = heading_reg + 2'd1;
                            done_next    = 1'b1;
                            last_next    = 1'b1;
                        end
                        tgp_pkg::KIND_TURN_L:
                        begin
                            heading_next = heading_reg - 2'd1;
                            done_next    = 1'b1;
                            last_next    = 1'b1;
                        end
                        tgp_pkg::KIND_MOVE:
                        begin
                            if (horiz)
                            begin
                                col_pos_next = new_p;
                            end
                            else
                            begin
                                row_pos_next = new_p;
                            end
                            clamp_next = clamp;
                            if (pen_reg && (mark_cnt != '0))
                            begin
                                state_next = ST_MARK;
                                if (horiz)
                                begin
                                    mask_next    = run_mask;
                                    rd_addr_next = row_pos_reg;
                                    rd_left_next = CW'(1);
                                end
                                else
                                begin
                                    mask_next    = col_mask;
                                    rd_addr_next = lo;
                                    rd_left_next = CW'(mark_cnt);
                                end
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                status_next = clamp;
                                last_next   = 1'b1;
                            end
                        end
                        tgp_pkg::KIND_DUMP:
                        begin
                            state_next   = ST_DUMP;
                            rd_addr_next = '0;
                            rd_left_next = CW'(G);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MARK:
            begin
                // final write-back lands at this edge, move result goes out with it
                if (!rd_en && pend_reg)
                begin
                    state_next  = ST_IDLE;
                    done_next   = 1'b1;
                    status_next = clamp_reg;
                    last_next   = 1'b1;
                end
            end
            ST_DUMP:
            begin
                if (pend_reg)
                begin
                    done_next      = 1'b1;
                    row_bits_next  = row_data;
                    row_index_next = IW'(pend_addr_reg);
                    last_next      = (pend_addr_reg == PW'(G - 1));
                    if (pend_addr_reg == PW'(G - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pen_reg       <= 1'b0;
            heading_reg   <= tgp_pkg::HEAD_W;
            row_pos_reg   <= PW'(tgp_pkg::START_CLAMP);
            col_pos_reg   <= PW'(tgp_pkg::START_CLAMP);
            rd_left_reg   <= '0;
            pend_reg      <= 1'b0;
            row_valid_reg <= '0;
            done_reg      <= 1'b0;
            row_bits_reg  <= '0;
            row_index_reg <= '0;
            status_reg    <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pen_reg       <= pen_next;
            heading_reg   <= heading_next;
            row_pos_reg   <= row_pos_next;
            col_pos_reg   <= col_pos_next;
            rd_left_reg   <= rd_left_next;
            pend_reg      <= pend_next;
            row_valid_reg <= row_valid_next;
            done_reg      <= done_next;
            row_bits_reg  <= row_bits_next;
            row_index_reg <= row_index_next;
            status_reg    <= status_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg      <= mask_next;
        rd_addr_reg   <= rd_addr_next;
        pend_addr_reg <= pend_addr_next;
        clamp_reg     <= clamp_next;
    end

    // grid memory: rows touched by one move are distinct, so read and write never collide
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[pend_addr_reg] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q       <= mem[rd_addr_reg];
            q_valid_reg <= row_valid_reg[rd_addr_reg];
        end
    end

endmodule

// ===== rtl/tgp_checker.sv =====
// port-level checker for the turtle grid plotter, bound to the top level
// depends on tgp_pkg and turtle_grid_plotter_unit_macros.svh
`include "turtle_grid_plotter_unit_macros.svh"

module tgp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic [2:0]  kind,
    input logic        busy,
    input logic        done,
    input logic [63:0] row_bits,
    input logic [5:0]  row_index,
    input logic        status,
    input logic        last
);

    // a dump transaction keeps the unit busy
    `TGP_ASSERT_NEXT(a_dump_busy, clk, rst_n, start && !busy && (kind == tgp_pkg::KIND_DUMP), busy)

    // dump rows come out back to back
    `TGP_ASSERT_NEXT(a_rows_back_to_back, clk, rst_n, done && !last, done)

    // a row past the first follows its predecessor directly
    `TGP_ASSERT_NOW(a_row_order, clk, rst_n, done && (row_index != 6'd0), $past(done) && (row_index == $past(row_index) + 6'd1))

    // clamp status only on single results with no row data
    `TGP_ASSERT_NOW(a_status_single, clk, rst_n, status, done && last && (row_bits == 64'd0))

    // a dump still in progress holds off new transactions
    `TGP_ASSERT_NOW(a_dump_holds_busy, clk, rst_n, done && !last, busy)

endmodule

bind turtle_grid_plotter_unit tgp_checker u_tgp_checker (.*);

// ===== tb/turtle_grid_plotter_unit_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for turtle_grid_plotter_unit: directed command table, then
// random command streams checked against a behavioral plotter; depends on tgp_pkg
module turtle_grid_plotter_unit_test;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 335;
    localparam int QUIET_FIRST  = 120;
    localparam int QUIET_LAST   = 200;
    localparam int DRAIN_POINT  = 250;

    typedef struct {
        logic [63:0] row_bits;
        logic [5:0]  row_index;
        logic        status;
        logic        last;
    } plot_result_t;

    typedef struct {
        logic [2:0] kind;
        logic [5:0] steps;
        bit         typed;
        bit         typed_status;
    } plot_cmd_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [2:0]  kind = 3'd0;
    logic [5:0]  steps = 6'd0;
    logic        busy;
    logic        done;
    logic [63:0] row_bits;
    logic [5:0]  row_index;
    logic        status;
    logic        last;

    // behavioral copy of the plotter state
    logic [63:0] plot_grid [tgp_pkg::GRID_SIZE];
    int          turtle_row;
    int          turtle_col;
    logic [1:0]  turtle_heading;
    bit          turtle_pen;

    plot_result_t plot_results_q[$];
    plot_cmd_t    directed_cmds[$];
    plot_result_t want;

    int errors = 0;
    int cycles = 0;
    int n_items = 0;
    int n_checked = 0;
    int n_dumps = 0;
    int n_clamps = 0;
    int n_marked_moves = 0;

    turtle_grid_plotter_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .kind      (kind),
        .steps     (steps),
        .busy      (busy),
        .done      (done),
        .row_bits  (row_bits),
        .row_index (row_index),
        .status    (status),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still expected", $time,
                     plot_results_q.size());
            $display("** turtle_grid_plotter_unit: FAILED **");
            $finish;
        end
    end

    function automatic int clamp_to_grid(input int p, inout bit clamped);
        if (p < 0)
        begin
            clamped = 1'b1;
            return 0;
        end
        if (p > tgp_pkg::GRID_SIZE - 1)
        begin
            clamped = 1'b1;
            return tgp_pkg::GRID_SIZE - 1;
        end
        return p;
    endfunction

    // updates the turtle and queues the results one accepted command causes;
    // a typed status or a typed cleared dump replaces the computed value
    task automatic plot_command(input logic [2:0] k, input logic [5:0] s,
                                input bit typed, input bit typed_status);
        plot_result_t res;
        int dr;
        int dc;
        int r;
        int c;
        bit clamped;
        dr = 0;
        dc = 0;
        clamped = 1'b0;
        case (k)
            tgp_pkg::KIND_PEN_UP:   turtle_pen = 1'b0;
            tgp_pkg::KIND_PEN_DOWN: turtle_pen = 1'b1;
            tgp_pkg::KIND_TURN_R:   turtle_heading = turtle_heading + 2'd1;
            tgp_pkg::KIND_TURN_L:   turtle_heading = turtle_heading - 2'd1;
            tgp_pkg::KIND_MOVE:
            begin
                case (turtle_heading)
                    tgp_pkg::HEAD_W: dc = -1;
                    tgp_pkg::HEAD_S: dr = 1;
                    tgp_pkg::HEAD_E: dc = 1;
                    default:         dr = -1;
                endcase
                if (turtle_pen && s != 0)
                    n_marked_moves++;
                if (turtle_pen)
                    for (int x = 0; x < int'(s); x++)
                    begin
                        r = turtle_row + dr * x;
                        c = turtle_col + dc * x;
                        if (r >= 0 && r < tgp_pkg::GRID_SIZE && c >= 0
                            && c < tgp_pkg::GRID_SIZE)
                            plot_grid[r][c] = 1'b1;
                    end
                turtle_row = clamp_to_grid(turtle_row + dr * int'(s), clamped);
                turtle_col = clamp_to_grid(turtle_col + dc * int'(s), clamped);
                if (clamped)
                    n_clamps++;
            end
            tgp_pkg::KIND_DUMP:
            begin
                n_dumps++;
                for (int i = 0; i < tgp_pkg::GRID_SIZE; i++)
                begin
                    res.row_bits  = typed ? 64'd0 : plot_grid[i];
                    res.row_index = i[5:0];
                    res.status    = 1'b0;
                    res.last      = (i == tgp_pkg::GRID_SIZE - 1);
                    plot_results_q.push_back(res);
                end
            end
            default: ;
        endcase
        if (k < tgp_pkg::KIND_DUMP)
        begin
            res.row_bits  = 64'd0;
            res.row_index = 6'd0;
            res.status    = typed ? typed_status : clamped;
            res.last      = 1'b1;
            plot_results_q.push_back(res);
        end
    endtask

    // start stays high between back-to-back transactions
    task automatic issue(input logic [2:0] k, input logic [5:0] s,
                         input bit typed, input bit typed_status);
        start <= 1'b1;
        kind  <= k;
        steps <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        plot_command(k, s, typed, typed_status);
        if (k <= tgp_pkg::KIND_DUMP)
            n_items++;
    endtask

    // each cycle idles with about a one in three chance outside the quiet stretch
    task automatic sender_gap(input int idx);
        if (idx < QUIET_FIRST || idx > QUIET_LAST)
        begin
            while ($urandom_range(0, 99) < 34)
            begin
                start <= 1'b0;
                kind  <= 3'($urandom);
                steps <= 6'($urandom);
                @(posedge clk);
            end
        end
    endtask

    task automatic add_cmd(input logic [2:0] k, input logic [5:0] s,
                           input bit typed, input bit typed_status);
        plot_cmd_t cmd;
        cmd.kind = k;
        cmd.steps = s;
        cmd.typed = typed;
        cmd.typed_status = typed_status;
        directed_cmds.push_back(cmd);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (plot_results_q.size() == 0)
            begin
                $display("%0t: result with nothing expected: row_bits %h row_index %0d",
                         $time, row_bits, row_index);
                errors++;
            end
            else
            begin
                want = plot_results_q.pop_front();
                n_checked++;
                if (row_bits !== want.row_bits)
                begin
                    $display("%0t: row_bits expected %h actual %h", $time,
                             want.row_bits, row_bits);
                    errors++;
                end
                if (row_index !== want.row_index)
                begin
                    $display("%0t: row_index expected %0d actual %0d", $time,
                             want.row_index, row_index);
                    errors++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status expected %b actual %b", $time,
                             want.status, status);
                    errors++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last expected %b actual %b", $time, want.last, last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int n_random;
        int p;
        logic [2:0] k;
        logic [5:0] s;
        plot_cmd_t cmd;

        for (int i = 0; i < tgp_pkg::GRID_SIZE; i++)
            plot_grid[i] = 64'd0;
        turtle_row = tgp_pkg::START_CLAMP;
        turtle_col = tgp_pkg::START_CLAMP;
        turtle_heading = tgp_pkg::HEAD_W;
        turtle_pen = 1'b0;

        // cleared grid, then strokes clamped at the left and bottom edges
        add_cmd(tgp_pkg::KIND_DUMP,      6'd0,  1'b1, 1'b0);
        add_cmd(tgp_pkg::KIND_MOVE,      6'd0,  1'b1, 1'b0);
        add_cmd(tgp_pkg::KIND_PEN_DOWN,  6'd0,  1'b1, 1'b0);
        add_cmd(tgp_pkg::KIND_MOVE,      6'd63, 1'b1, 1'b1);
        add_cmd(tgp_pkg::KIND_TURN_L,    6'd0,  1'b1, 1'b0);
        add_cmd(tgp_pkg::KIND_TURN_R,    6'd0,  1'b1, 1'b0);
        add_cmd(tgp_pkg::KIND_TURN_R,    6'd0,  1'b1, 1'b0);
        add_cmd(tgp_pkg::KIND_MOVE,      6'd63, 1'b1, 1'b1);
        add_cmd(tgp_pkg::KIND_TURN_R,    6'd0,  1'b1, 1'b0);
        // full width from the left edge lands exactly on the right edge
        add_cmd(tgp_pkg::KIND_MOVE,      6'd63, 1'b1, 1'b0);
        add_cmd(tgp_pkg::KIND_TURN_R,    6'd0,  1'b1, 1'b0);
        add_cmd(tgp_pkg::KIND_MOVE,      6'd63, 1'b0, 1'b0);
        add_cmd(tgp_pkg::KIND_MOVE,      6'd1,  1'b1, 1'b1);
        // clamping with the pen up
        add_cmd(tgp_pkg::KIND_PEN_UP,    6'd0,  1'b1, 1'b0);
        add_cmd(tgp_pkg::KIND_TURN_L,    6'd0,  1'b1, 1'b0);
        add_cmd(tgp_pkg::KIND_MOVE,      6'd5,  1'b1, 1'b1);
        // unused codes are dropped
        add_cmd(3'd6,                    6'd63, 1'b0, 1'b0);
        add_cmd(3'd7,                    6'd42, 1'b0, 1'b0);
        // heading wraps left from zero, zero-length move with the pen down
        add_cmd(tgp_pkg::KIND_PEN_DOWN,  6'd0,  1'b1, 1'b0);
        add_cmd(tgp_pkg::KIND_TURN_L,    6'd0,  1'b1, 1'b0);
        add_cmd(tgp_pkg::KIND_TURN_L,    6'd0,  1'b1, 1'b0);
        add_cmd(tgp_pkg::KIND_TURN_L,    6'd0,  1'b1, 1'b0);
        add_cmd(tgp_pkg::KIND_MOVE,      6'd0,  1'b1, 1'b0);
        add_cmd(tgp_pkg::KIND_MOVE,      6'd21, 1'b0, 1'b0);
        add_cmd(tgp_pkg::KIND_DUMP,      6'd63, 1'b0, 1'b0);

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < directed_cmds.size(); i++)
        begin
            cmd = directed_cmds[i];
            issue(cmd.kind, cmd.steps, cmd.typed, cmd.typed_status);
            sender_gap(i);
        end

        n_random = 0;
        while (n_random < RANDOM_ITEMS)
        begin
            p = $urandom_range(0, 99);
            s = 6'($urandom);
            if (p < 4)
                k = 3'd6 + 3'($urandom_range(0, 1));
            else if (p < 9)
                k = tgp_pkg::KIND_DUMP;
            else if (p < 22)
                k = ($urandom_range(0, 3) == 0) ? tgp_pkg::KIND_PEN_UP
                                                : tgp_pkg::KIND_PEN_DOWN;
            else if (p < 42)
                k = $urandom_range(0, 1) ? tgp_pkg::KIND_TURN_R : tgp_pkg::KIND_TURN_L;
            else
            begin
                k = tgp_pkg::KIND_MOVE;
                // mostly short strokes so the turtle stays off the edges
                if ($urandom_range(0, 3) != 0)
                    s = 6'($urandom_range(0, 15));
            end
            issue(k, s, 1'b0, 1'b0);
            if (k <= tgp_pkg::KIND_DUMP)
                n_random++;
            if (n_random == DRAIN_POINT)
            begin
                start <= 1'b0;
                @(posedge clk);
                while (plot_results_q.size() > 0)
                    @(posedge clk);
            end
            sender_gap(n_random);
        end

        start <= 1'b0;
        @(posedge clk);
        while (plot_results_q.size() > 0)
            @(posedge clk);
        repeat (tgp_pkg::GRID_SIZE + 8)
            @(posedge clk);

        $display("%0d commands (%0d dumps, %0d clamped moves, %0d marking moves)",
                 n_items, n_dumps, n_clamps, n_marked_moves);
        $display("%0d results checked, %0d mismatches", n_checked, errors);
        if (errors == 0 && plot_results_q.size() == 0)
            $display("** turtle_grid_plotter_unit: PASSED **");
        else
            $display("** turtle_grid_plotter_unit: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tgp_pkg.sv
rtl/turtle_grid_plotter_unit.sv
rtl/tgp_checker.sv
tb/turtle_grid_plotter_unit_test.sv
